### rtl/assert_macros.svh
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, prop) lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error("assertion failed");
`define ASSERT_NEVER(lbl, cond) lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error("forbidden condition");
`else
`define ASSERT_IMPL(lbl, prop)
`define ASSERT_NEVER(lbl, cond)
`endif
`endif

### rtl/sclru_pkg.sv
package sclru_pkg;
  localparam logic [2:0] OP_READ = 3'd0;
  localparam logic [2:0] OP_WRITE = 3'd1;
  localparam logic [2:0] OP_PIN = 3'd2;
  localparam logic [2:0] OP_UNPIN = 3'd3;
  localparam logic [2:0] OP_ADVANCE = 3'd4;
  localparam logic [2:0] OP_BARRIER = 3'd5;
  localparam logic [2:0] OP_INVAL = 3'd6;
  localparam logic [2:0] OP_RSVD = 3'd7;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_RANGE = 3'd1;
  localparam logic [2:0] ST_NOVICTIM = 3'd2;
  localparam logic [2:0] ST_INVARG = 3'd3;
  localparam logic [2:0] ST_RDONLY = 3'd4;
  localparam logic [2:0] ST_OVERFLOW = 3'd5;
  localparam logic [2:0] ST_INVSTATE = 3'd6;
  localparam logic [2:0] ST_DEVERR = 3'd7;

  localparam logic [1:0] CFG_ENTRIES = 2'd0;
  localparam logic [1:0] CFG_SECTORS = 2'd1;
  localparam logic [1:0] CFG_RDONLY = 2'd2;

  localparam logic [1:0] K_EMPTY = 2'd0;
  localparam logic [1:0] K_CLEAN = 2'd1;
  localparam logic [1:0] K_DIRTY = 2'd2;
  localparam logic [1:0] K_FAILED = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [31:0] tag;
    logic [15:0] pins;
    logic [31:0] stamp;
    logic [31:0] dirty_gen;
  } entry_t;

  typedef struct packed {
    logic [2:0] operation;
    logic [31:0] sector;
    logic [31:0] generation;
    logic device_failed;
    logic [15:0] write_fail_mask;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] entry_index;
    logic hit;
    logic writeback;
    logic [31:0] writeback_sector;
    logic [31:0] new_generation;
    logic last;
  } rsp_t;

  // command broadcast to the cells for one rotation step
  typedef struct packed {
    logic shift;
    logic wr;
    entry_t wdata;
  } cell_ctl_t;
endpackage

### rtl/sclru_if.sv
interface sclru_req_if;
  import sclru_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

interface sclru_rsp_if;
  import sclru_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

interface sclru_cfg_if;
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [31:0] wdata;
  modport source (output valid, index, wdata, input ready);
  modport sink (input valid, index, wdata, output ready);
endinterface

### rtl/sector_cache_lru_policy_unit.sv
// Ring of ENTRIES cells rotating one entry per cycle past a head stage, save in the
// decision state and while a barrier notice waits. Read, write, pin, unpin, barrier:
// search pass, decision state, update pass. No new request is taken until the result
// is taken. Invalidate answers after its clearing pass; advance, bad barrier target
// and undefined op skip the passes. Notices add cycles only while the receiver stalls.
// Asynchronous reset empties all entries, use clock 0, generation 1, config to defaults.
`include "assert_macros.svh"
module sector_cache_lru_policy_unit
  import sclru_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  sclru_req_if.sink   req,
  sclru_rsp_if.source rsp,
  sclru_cfg_if.sink   cfg
);
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_P1 = 3'd1;
  localparam logic [2:0] S_P2 = 3'd2;
  localparam logic [2:0] S_P3 = 3'd3;
  localparam logic [2:0] S_OUT = 3'd4;

  entry_t ent [ENTRIES];
  entry_t head_new;
  cell_ctl_t ctl;

  // cell 0 takes the (possibly rewritten) last cell: a ring
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    cell_ctl_t c;
    always_comb begin
      c = ctl;
    end
    if (g == 0) begin : g_h
      sclru_cell u_cell (.clk_i, .rst_ni, .ctl_i(c), .prev_i(head_new), .ent_o(ent[g]));
    end else begin : g_b
      sclru_cell u_cell (.clk_i, .rst_ni, .ctl_i(c), .prev_i(ent[g-1]), .ent_o(ent[g]));
    end
  end

  entry_t cur;
  assign cur = ent[ENTRIES-1];

  logic [2:0] state_q, state_d;
  logic [IW-1:0] pos_q, pos_d;
  req_t r_q, r_d;
  logic [4:0] n_cfg_q, n_cfg_d;
  logic [31:0] sectors_q, sectors_d;
  logic ro_q, ro_d;
  logic [31:0] clk_q, clk_d, gen_q, gen_d;
  logic fnd_q, fnd_d, vic_q, vic_d, vemp_q, vemp_d, anyf_q, anyf_d;
  logic [IW-1:0] fidx_q, fidx_d, vidx_q, vidx_d;
  logic [31:0] vuse_q, vuse_d;
  logic [2:0] st_q, st_d;
  logic [IW-1:0] idx_q, idx_d;
  logic hit_q, hit_d;
  rsp_t out_q, out_d;
  logic ov_q, ov_d;
  logic busy_out;
  logic [CW-1:0] n;

  assign n = (32'(n_cfg_q) > 32'(ENTRIES)) ? CW'(ENTRIES) : CW'(n_cfg_q);
  assign busy_out = ov_q && !rsp.ready;
  assign req.ready = (state_q == S_IDLE) && !busy_out;
  assign cfg.ready = 1'b1;
  assign rsp.valid = ov_q;
  assign rsp.data = out_q;

  logic live, tdirty;
  assign live = {1'b0, pos_q} < (IW+1)'(n);
  assign tdirty = cur.kind >= K_DIRTY && cur.dirty_gen <= r_q.generation;

  function automatic rsp_t mk(logic [2:0] s, logic [IW-1:0] i, logic h, logic w,
                              logic [31:0] ws, logic [31:0] ng, logic l);
    rsp_t o;
    o.status = s;
    o.entry_index = 4'(i);
    o.hit = h;
    o.writeback = w;
    o.writeback_sector = ws;
    o.new_generation = ng;
    o.last = l;
    return o;
  endfunction

  always_comb begin
    state_d = state_q; pos_d = pos_q; r_d = r_q;
    n_cfg_d = n_cfg_q; sectors_d = sectors_q; ro_d = ro_q;
    clk_d = clk_q; gen_d = gen_q;
    fnd_d = fnd_q; vic_d = vic_q; vemp_d = vemp_q; anyf_d = anyf_q;
    fidx_d = fidx_q; vidx_d = vidx_q; vuse_d = vuse_q;
    st_d = st_q; idx_d = idx_q; hit_d = hit_q;
    out_d = out_q; ov_d = ov_q;
    ctl = '0;
    head_new = cur;
    if (ov_q && rsp.ready) ov_d = 1'b0;
    if (cfg.valid) begin
      unique case (cfg.index)
        CFG_ENTRIES: n_cfg_d = cfg.wdata[4:0];
        CFG_SECTORS: sectors_d = cfg.wdata;
        CFG_RDONLY: ro_d = cfg.wdata[0];
        default: ;
      endcase
    end
    unique case (state_q)
      S_IDLE: begin
        if (req.valid && req.ready) begin
          r_d = req.data;
          pos_d = '0; fnd_d = 1'b0; vic_d = 1'b0; vemp_d = 1'b0; anyf_d = 1'b0;
          st_d = ST_OK; idx_d = '0; hit_d = 1'b0;
          state_d = S_P1;
        end
      end
      S_P1: begin
        ctl.shift = 1'b1;
        unique case (r_q.operation)
          OP_READ, OP_WRITE, OP_PIN, OP_UNPIN: begin
            if (live && cur.kind != K_EMPTY && cur.tag == r_q.sector && !fnd_d) begin
              fnd_d = 1'b1; fidx_d = pos_q;
            end
            if (live && cur.pins == 16'd0 && !vemp_q) begin
              if (cur.kind == K_EMPTY) begin
                vic_d = 1'b1; vemp_d = 1'b1; vidx_d = pos_q;
              end else if (cur.kind == K_CLEAN && (!vic_q || cur.stamp < vuse_q)) begin
                vic_d = 1'b1; vidx_d = pos_q; vuse_d = cur.stamp;
              end
            end
          end
          OP_BARRIER: begin
            if (live && tdirty) begin
              head_new.kind = r_q.write_fail_mask[pos_q] ? K_FAILED : K_DIRTY;
              if (r_q.write_fail_mask[pos_q]) anyf_d = 1'b1;
              out_d = mk(r_q.write_fail_mask[pos_q] ? ST_DEVERR : ST_OK, pos_q, 1'b0,
                         1'b1, cur.tag, '0, 1'b0);
              ov_d = 1'b1;
            end
          end
          OP_INVAL: if (live) head_new = '0;
          default: ;
        endcase
        if (r_q.operation == OP_BARRIER && live && tdirty && busy_out) begin
          ctl.shift = 1'b0; head_new = cur;
          anyf_d = anyf_q; out_d = out_q; ov_d = ov_q;
        end
        if (ctl.shift) begin
          pos_d = pos_q + 1'b1;
          if (pos_q == IW'(ENTRIES-1)) begin
            pos_d = '0;
            state_d = S_P2;
            priority if (r_q.operation == OP_BARRIER) begin
              if (r_q.generation == 0 || r_q.generation > gen_q) state_d = S_OUT;
            end else if (r_q.operation == OP_INVAL || r_q.operation == OP_ADVANCE ||
                         r_q.operation == OP_RSVD) begin
              state_d = S_OUT;
            end
          end
        end
        // barrier precheck before any notice
        if (r_q.operation == OP_BARRIER && pos_q == '0 &&
            (r_q.generation == 0 || r_q.generation > gen_q)) begin
          ctl.shift = 1'b0; head_new = cur; out_d = out_q; ov_d = ov_q && !rsp.ready;
          anyf_d = anyf_q; st_d = ST_INVARG; state_d = S_OUT;
        end
        if (r_q.operation == OP_INVAL && pos_q == IW'(ENTRIES-1)) clk_d = '0;
        if (r_q.operation == OP_ADVANCE) begin
          ctl.shift = 1'b0; head_new = cur; state_d = S_OUT;
          if (gen_q == '1) st_d = ST_OVERFLOW;
          else gen_d = gen_q + 1'b1;
        end
        if (r_q.operation == OP_RSVD) begin
          ctl.shift = 1'b0; head_new = cur; st_d = ST_INVARG; state_d = S_OUT;
        end
      end
      S_P2: begin
        ctl.shift = 1'b1;
        if (pos_q == '0) begin
          // decide the outcome before touching entries
          priority if (r_q.operation == OP_BARRIER) begin
            st_d = anyf_q ? ST_DEVERR : (r_q.device_failed ? ST_DEVERR : ST_OK);
          end else if (r_q.operation == OP_UNPIN) begin
            vic_d = 1'b0;
            if (!fnd_q) st_d = ST_INVSTATE;
            else begin idx_d = fidx_q; hit_d = 1'b1; end
          end else if (r_q.operation == OP_WRITE &&
                       (r_q.generation == 0 || r_q.generation > gen_q)) begin
            st_d = ST_INVARG; fnd_d = 1'b0; vic_d = 1'b0;
          end else if (r_q.operation == OP_WRITE && ro_q) begin
            st_d = ST_RDONLY; fnd_d = 1'b0; vic_d = 1'b0;
          end else if (r_q.sector >= sectors_q) begin
            st_d = ST_RANGE; fnd_d = 1'b0; vic_d = 1'b0;
          end else if (fnd_q) begin
            idx_d = fidx_q; hit_d = 1'b1; vic_d = 1'b0; clk_d = clk_q + 1'b1;
          end else if (vic_q) begin
            idx_d = vidx_q; clk_d = clk_q + 1'b1;
          end else begin
            st_d = ST_NOVICTIM;
          end
          ctl.shift = 1'b0;
          state_d = S_P3;
        end
      end
      S_P3: begin
        ctl.shift = 1'b1;
        if ((fnd_q && pos_q == fidx_q) || (vic_q && pos_q == vidx_q)) begin
          unique case (r_q.operation)
            OP_UNPIN: begin
              if (cur.pins == 16'd0) st_d = ST_INVSTATE;
              else head_new.pins = cur.pins - 1'b1;
            end
            default: begin
              if (vic_q) begin
                head_new = '0;
                head_new.tag = r_q.sector;
                head_new.kind = K_CLEAN;
              end
              head_new.stamp = clk_q;
              if ((r_q.operation == OP_READ || r_q.operation == OP_PIN) && vic_q &&
                  r_q.device_failed) begin
                head_new = '0; st_d = ST_DEVERR;
              end else if (r_q.operation == OP_WRITE) begin
                head_new.kind = K_DIRTY; head_new.dirty_gen = r_q.generation;
              end else if (r_q.operation == OP_PIN) begin
                if (head_new.pins == 16'hFFFF) st_d = ST_OVERFLOW;
                else head_new.pins = head_new.pins + 1'b1;
              end
            end
          endcase
        end
        if (r_q.operation == OP_BARRIER && live && tdirty && !anyf_q) begin
          if (r_q.device_failed) begin
            if (cur.kind == K_DIRTY) head_new.kind = K_FAILED;
          end else begin
            head_new.kind = K_CLEAN; head_new.dirty_gen = '0;
          end
        end
        pos_d = pos_q + 1'b1;
        if (pos_q == IW'(ENTRIES-1)) begin pos_d = '0; state_d = S_OUT; end
      end
      S_OUT: begin
        if (!busy_out) begin
          out_d = mk(st_q, idx_q, hit_q, 1'b0, '0,
                     (r_q.operation == OP_ADVANCE && st_q == ST_OK) ? gen_q : '0, 1'b1);
          ov_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; pos_q <= '0; ov_q <= 1'b0;
      n_cfg_q <= 5'd16; sectors_q <= '1; ro_q <= 1'b0;
      clk_q <= '0; gen_q <= 32'd1;
      fnd_q <= 1'b0; vic_q <= 1'b0; vemp_q <= 1'b0; anyf_q <= 1'b0;
    end else begin
      state_q <= state_d; pos_q <= pos_d; ov_q <= ov_d;
      n_cfg_q <= n_cfg_d; sectors_q <= sectors_d; ro_q <= ro_d;
      clk_q <= clk_d; gen_q <= gen_d;
      fnd_q <= fnd_d; vic_q <= vic_d; vemp_q <= vemp_d; anyf_q <= anyf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d; fidx_q <= fidx_d; vidx_q <= vidx_d; vuse_q <= vuse_d;
    st_q <= st_d; idx_q <= idx_d; hit_q <= hit_d; out_q <= out_d;
  end

  `ASSERT_IMPL(a_hold, ov_q && !rsp.ready |=> ov_q && $stable(out_q))
  `ASSERT_NEVER(a_accept_busy, req.valid && req.ready && state_q != S_IDLE)
  `ASSERT_IMPL(a_gen_nz, gen_q != 32'd0)
endmodule

### rtl/sclru_cell.sv
module sclru_cell
  import sclru_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_ctl_t ctl_i,
  input  entry_t    prev_i,
  output entry_t    ent_o
);
  entry_t ent_q, ent_d;
  always_comb begin
    ent_d = ent_q;
    if (ctl_i.shift) begin
      ent_d = prev_i;
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
    end else begin
      ent_q <= ent_d;
    end
  end
  assign ent_o = ent_q;
endmodule

### test/tb.sv
`timescale 1ns / 1ps
module tb;
  import sclru_pkg::*;

  localparam int NENT = 16;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  sclru_req_if req_ch ();
  sclru_rsp_if rsp_ch ();
  sclru_cfg_if cfg_ch ();

  sector_cache_lru_policy_unit #(.ENTRIES(NENT)) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req   (req_ch.sink),
    .rsp   (rsp_ch.source),
    .cfg   (cfg_ch.sink)
  );

  // cache shadow
  logic [1:0]  sh_kind [NENT];
  logic [31:0] sh_tag  [NENT];
  logic [15:0] sh_pins [NENT];
  logic [31:0] sh_use  [NENT];
  logic [31:0] sh_dgen [NENT];
  logic [31:0] sh_clock;
  logic [31:0] sh_gen;
  logic [4:0]  sh_nent;
  logic [31:0] sh_sectors;
  logic        sh_rdonly;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int   errors = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  bit   send_hold = 1'b0;
  longint cycles = 0;

  function automatic int live_n();
    return (sh_nent > NENT) ? NENT : int'(sh_nent);
  endfunction

  function automatic void clear_slot(int i);
    sh_kind[i] = K_EMPTY;
    sh_tag[i]  = '0;
    sh_pins[i] = '0;
    sh_use[i]  = '0;
    sh_dgen[i] = '0;
  endfunction

  function automatic int find_tag(logic [31:0] s);
    for (int i = 0; i < live_n(); i++)
      if (sh_kind[i] != K_EMPTY && sh_tag[i] == s) return i;
    return -1;
  endfunction

  function automatic logic [2:0] claim_slot(logic [31:0] s, bit load, bit fail,
                                            output logic [3:0] idx, output logic hit);
    int f;
    int v;
    idx = '0;
    hit = 1'b0;
    v = -1;
    if (s >= sh_sectors) return ST_RANGE;
    f = find_tag(s);
    if (f >= 0) begin
      sh_clock++;
      sh_use[f] = sh_clock;
      idx = f[3:0];
      hit = 1'b1;
      return ST_OK;
    end
    for (int i = 0; i < live_n(); i++) begin
      if (sh_pins[i] != 0) continue;
      if (sh_kind[i] == K_EMPTY) begin
        v = i;
        break;
      end
      if (sh_kind[i] == K_CLEAN && (v < 0 || sh_use[i] < sh_use[v])) v = i;
    end
    if (v < 0) return ST_NOVICTIM;
    clear_slot(v);
    sh_tag[v] = s;
    sh_clock++;
    sh_use[v] = sh_clock;
    idx = v[3:0];
    if (load && fail) begin
      clear_slot(v);
      return ST_DEVERR;
    end
    sh_kind[v] = K_CLEAN;
    return ST_OK;
  endfunction

  function automatic rsp_t mk_rsp(logic [2:0] st, logic [3:0] idx, logic hit, logic wb,
                                  logic [31:0] wsec, logic [31:0] ng, logic lst);
    rsp_t r;
    r.status = st;
    r.entry_index = idx;
    r.hit = hit;
    r.writeback = wb;
    r.writeback_sector = wsec;
    r.new_generation = ng;
    r.last = lst;
    return r;
  endfunction

  function automatic void predict_cache(req_t q);
    logic [3:0] idx;
    logic hit;
    logic [2:0] st;
    int f;
    bit any_bad;
    bit bad;
    idx = '0;
    hit = 1'b0;
    any_bad = 1'b0;
    case (q.operation)
      OP_READ: st = claim_slot(q.sector, 1'b1, q.device_failed, idx, hit);
      OP_WRITE: begin
        if (q.generation == 0 || q.generation > sh_gen) st = ST_INVARG;
        else if (sh_rdonly) st = ST_RDONLY;
        else begin
          st = claim_slot(q.sector, 1'b0, 1'b0, idx, hit);
          if (st == ST_OK) begin
            sh_dgen[idx] = q.generation;
            sh_kind[idx] = K_DIRTY;
          end
        end
      end
      OP_PIN: begin
        st = claim_slot(q.sector, 1'b1, q.device_failed, idx, hit);
        if (st == ST_OK) begin
          if (sh_pins[idx] == 16'hFFFF) st = ST_OVERFLOW;
          else sh_pins[idx]++;
        end
      end
      OP_UNPIN: begin
        f = find_tag(q.sector);
        if (f < 0) st = ST_INVSTATE;
        else begin
          idx = f[3:0];
          hit = 1'b1;
          if (sh_pins[f] == 0) st = ST_INVSTATE;
          else begin
            sh_pins[f]--;
            st = ST_OK;
          end
        end
      end
      OP_ADVANCE: begin
        if (sh_gen == 32'hFFFF_FFFF) st = ST_OVERFLOW;
        else begin
          sh_gen++;
          expected_rsps.push_back(mk_rsp(ST_OK, '0, 1'b0, 1'b0, '0, sh_gen, 1'b1));
          return;
        end
      end
      OP_BARRIER: begin
        if (q.generation == 0 || q.generation > sh_gen) st = ST_INVARG;
        else begin
          for (int i = 0; i < live_n(); i++) begin
            if (sh_kind[i] < K_DIRTY || sh_dgen[i] > q.generation) continue;
            bad = q.write_fail_mask[i];
            sh_kind[i] = bad ? K_FAILED : K_DIRTY;
            if (bad) any_bad = 1'b1;
            expected_rsps.push_back(mk_rsp(bad ? ST_DEVERR : ST_OK, i[3:0], 1'b0, 1'b1,
                                           sh_tag[i], '0, 1'b0));
          end
          if (any_bad) st = ST_DEVERR;
          else if (q.device_failed) begin
            for (int i = 0; i < live_n(); i++)
              if (sh_kind[i] == K_DIRTY && sh_dgen[i] <= q.generation) sh_kind[i] = K_FAILED;
            st = ST_DEVERR;
          end else begin
            for (int i = 0; i < live_n(); i++)
              if (sh_kind[i] >= K_DIRTY && sh_dgen[i] <= q.generation) begin
                sh_kind[i] = K_CLEAN;
                sh_dgen[i] = '0;
              end
            st = ST_OK;
          end
        end
      end
      OP_INVAL: begin
        for (int i = 0; i < live_n(); i++) clear_slot(i);
        sh_clock = '0;
        st = ST_OK;
      end
      default: st = ST_INVARG;
    endcase
    expected_rsps.push_back(mk_rsp(st, idx, hit, 1'b0, '0, '0, 1'b1));
  endfunction

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
      req_ch.data  <= '0;
    end else begin
      if (req_ch.valid && req_ch.ready) predict_cache(req_ch.data);
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_reqs.size() > 0 && !send_hold &&
            $urandom_range(99) >= send_idle_pct) begin
          req_ch.valid <= 1'b1;
          req_ch.data  <= pending_reqs.pop_front();
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // response monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      cycles++;
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_rsps.size() == 0) begin
          errors++;
          $display("%0t: unexpected transaction %p", $time, rsp_ch.data);
        end else begin
          rsp_t e;
          e = expected_rsps.pop_front();
          if (e !== rsp_ch.data) begin
            errors++;
            $display("%0t: mismatch expected %p actual %p", $time, e, rsp_ch.data);
          end
        end
      end
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      if (cycles > CYCLE_LIMIT) begin
        $display("FAIL sector_cache_lru_policy_unit");
        $finish;
      end
    end
  end

  function automatic req_t mk_req(logic [2:0] op, logic [31:0] s, logic [31:0] g,
                                  logic df, logic [15:0] m);
    req_t q;
    q.operation = op;
    q.sector = s;
    q.generation = g;
    q.device_failed = df;
    q.write_fail_mask = m;
    return q;
  endfunction

  task automatic drain();
    while (pending_reqs.size() > 0 || req_ch.valid || expected_rsps.size() > 0)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.wdata <= val;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
    case (idx)
      CFG_ENTRIES: sh_nent = val[4:0];
      CFG_SECTORS: sh_sectors = val;
      CFG_RDONLY: sh_rdonly = val[0];
      default: ;
    endcase
  endtask

  function automatic logic [31:0] pick_sector();
    if ($urandom_range(9) == 0) return $urandom();
    return $urandom_range(23);
  endfunction

  task automatic add_random(int count);
    req_t q;
    int r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99);
      q = mk_req(OP_READ, pick_sector(), $urandom_range(1, 6), $urandom_range(9) == 0,
                 $urandom_range(7) == 0 ? 16'($urandom()) : 16'h0);
      if (r < 30) q.operation = OP_READ;
      else if (r < 55) q.operation = OP_WRITE;
      else if (r < 66) q.operation = OP_PIN;
      else if (r < 77) q.operation = OP_UNPIN;
      else if (r < 82) q.operation = OP_ADVANCE;
      else if (r < 94) q.operation = OP_BARRIER;
      else if (r < 97) q.operation = OP_INVAL;
      else q.operation = 3'($urandom_range(7));
      if ($urandom_range(15) == 0) q.generation = $urandom();
      pending_reqs.push_back(q);
    end
  endtask

  initial begin
    for (int i = 0; i < NENT; i++) clear_slot(i);
    sh_clock = '0;
    sh_gen = 32'd1;
    sh_nent = 5'd16;
    sh_sectors = 32'hFFFF_FFFF;
    sh_rdonly = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.wdata = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed
    pending_reqs.push_back(mk_req(OP_READ, 32'hFFFF_FFFF, 32'd0, 1'b0, 16'h0));
    pending_reqs.push_back(mk_req(OP_READ, 32'hFFFF_FFFE, 32'd0, 1'b0, 16'h0));
    pending_reqs.push_back(mk_req(OP_READ, 32'd0, 32'd0, 1'b1, 16'h0));
    pending_reqs.push_back(mk_req(OP_READ, 32'd0, 32'hFFFF_FFFF, 1'b0, 16'hFFFF));
    pending_reqs.push_back(mk_req(OP_READ, 32'd0, 32'd0, 1'b0, 16'h0));
    pending_reqs.push_back(mk_req(OP_WRITE, 32'd5, 32'd0, 1'b0, 16'h0));
    pending_reqs.push_back(mk_req(OP_WRITE, 32'd5, 32'd2, 1'b0, 16'h0));
    pending_reqs.push_back(mk_req(OP_WRITE, 32'd5, 32'd1, 1'b0, 16'h0));
    pending_reqs.push_back(mk_req(OP_ADVANCE, 32'd0, 32'd0, 1'b0, 16'h0));
    pending_reqs.push_back(mk_req(OP_WRITE, 32'd6, 32'd2, 1'b0, 16'h0));
    pending_reqs.push_back(mk_req(OP_PIN, 32'd7, 32'd0, 1'b0, 16'h0));
    pending_reqs.push_back(mk_req(OP_PIN, 32'd8, 32'd0, 1'b1, 16'h0));
    pending_reqs.push_back(mk_req(OP_UNPIN, 32'd7, 32'd0, 1'b0, 16'h0));
    pending_reqs.push_back(mk_req(OP_UNPIN, 32'd7, 32'd0, 1'b0, 16'h0));
    pending_reqs.push_back(mk_req(OP_UNPIN, 32'd99, 32'd0, 1'b0, 16'h0));
    pending_reqs.push_back(mk_req(OP_BARRIER, 32'd0, 32'd0, 1'b0, 16'h0));
    pending_reqs.push_back(mk_req(OP_BARRIER, 32'd0, 32'd9, 1'b0, 16'h0));
    pending_reqs.push_back(mk_req(OP_BARRIER, 32'd0, 32'd2, 1'b0, 16'h0002));
    pending_reqs.push_back(mk_req(OP_BARRIER, 32'd0, 32'd2, 1'b1, 16'h0));
    pending_reqs.push_back(mk_req(OP_BARRIER, 32'd0, 32'd2, 1'b0, 16'h0));
    pending_reqs.push_back(mk_req(OP_RSVD, 32'd0, 32'd0, 1'b0, 16'h0));
    pending_reqs.push_back(mk_req(OP_INVAL, 32'd0, 32'd0, 1'b0, 16'h0));
    drain();

    // all entries dirty: no victim
    for (int i = 0; i < 16; i++)
      pending_reqs.push_back(mk_req(OP_WRITE, 32'(100 + i), 32'd1, 1'b0, 16'h0));
    pending_reqs.push_back(mk_req(OP_READ, 32'd200, 32'd0, 1'b0, 16'h0));
    pending_reqs.push_back(mk_req(OP_BARRIER, 32'd0, 32'd1, 1'b0, 16'hA5A5));
    pending_reqs.push_back(mk_req(OP_BARRIER, 32'd0, 32'd2, 1'b0, 16'h0));
    // sender holds until every expected result has come
    while (pending_reqs.size() > 0) @(posedge clk_i);
    send_hold = 1'b1;
    pending_reqs.push_back(mk_req(OP_INVAL, 32'd0, 32'd0, 1'b0, 16'h0));
    while (req_ch.valid || expected_rsps.size() > 0) @(posedge clk_i);
    send_hold = 1'b0;
    drain();

    write_reg(CFG_RDONLY, 32'd1);
    write_reg(CFG_SECTORS, 32'd20);
    write_reg(CFG_ENTRIES, 32'd1);
    pending_reqs.push_back(mk_req(OP_WRITE, 32'd3, 32'd1, 1'b0, 16'h0));
    pending_reqs.push_back(mk_req(OP_READ, 32'd20, 32'd0, 1'b0, 16'h0));
    add_random(20);
    drain();
    write_reg(CFG_ENTRIES, 32'd0);
    write_reg(CFG_RDONLY, 32'd0);
    write_reg(CFG_SECTORS, 32'd0);
    add_random(8);
    drain();
    write_reg(CFG_SECTORS, 32'hFFFF_FFFF);
    write_reg(CFG_ENTRIES, 32'd31);
    add_random(25);
    drain();
    write_reg(CFG_ENTRIES, 32'd16);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1 || ph == 3) ? 70 : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? 70 : 0;
      if (ph == 3) begin
        send_idle_pct = 7;
        recv_stall_pct = 7;
      end
      if (ph == 2) write_reg(CFG_ENTRIES, 32'd5);
      add_random(30);
      drain();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (100) @(posedge clk_i);
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("PASS sector_cache_lru_policy_unit");
    end else begin
      $display("FAIL sector_cache_lru_policy_unit");
    end
    $finish;
  end
endmodule
